/* hw/rtl/chr_pkg.sv */
package chr_pkg;

   localparam int RING_BYTES_DEF = 256;
   localparam int RECALL_MAX     = 64;
   localparam int CNT_W          = 13;
   localparam int CFG_W          = 7;
   localparam logic [CFG_W-1:0] RECALL_LEN_RESET = 7'd64;

   typedef enum logic [2:0] {
      CMD_APPEND = 3'd0,
      CMD_OLDER  = 3'd1,
      CMD_NEWER  = 3'd2,
      CMD_GET_ID = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      OP_COMMIT,
      OP_REJECT,
      OP_OLDER,
      OP_NEWER,
      OP_GET_ID,
      OP_CLEAR
   } op_type;

   localparam logic [1:0] ST_STORED = 2'd0;
   localparam logic [1:0] ST_DUP    = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_CHAR   = 1'b1;

   typedef struct packed {
      op_type             op;
      logic signed [8:0]  id;
      logic [CNT_W-1:0]   count;
   } entry_type;

   typedef struct packed {
      logic sweeping;
      logic commit_done;
   } back_status_type;

   typedef enum logic [3:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_WALK_RD,
      BK_WALK_CHK,
      BK_DUP_RD,
      BK_DUP_CHK,
      BK_WR_RD,
      BK_WR_DO,
      BK_EV_ZERO,
      BK_EV_CHK,
      BK_RC_RD,
      BK_RC_CHK
   } back_state_type;

endpackage

/* hw/rtl/command_history_ring.sv */
// A nonzero append byte is written into the staging RAM. A commit walks back over the newest
// line, compares it byte by byte with the staged line and, if they differ, writes the staged
// bytes and evicts old lines; a recall walks to its line and returns its bytes. Results
// are registered. One word per cycle is taken while busy is low; busy is high while the
// two-entry queue is full, from a commit until its status is out, and after reset and after a
// clear while the ring is zeroed. Synchronous reset. Results strobe once; the receiver cannot stall.
module command_history_ring import chr_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   localparam int AW = $clog2(RING_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_command,
   input  logic [7:0]        req_char_in,
   input  logic signed [8:0] req_entry_id,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data,
   output logic              rsp_strobe,
   output logic              rsp_result_kind,
   output logic [1:0]        rsp_append_status,
   output logic [7:0]        rsp_out_char,
   output logic signed [6:0] rsp_length_code,
   output logic              rsp_last_of_run,
   output logic [7:0]        rsp_entry_count
);

   logic [CFG_W-1:0] recall_len_ff, recall_len_in;
   logic             q_full;
   logic             push;
   entry_type        push_entry;
   logic             q_pop;
   logic             q_valid;
   entry_type        q_entry;
   logic             stg_wr_en;
   logic [AW-1:0]    stg_wr_addr;
   logic [7:0]       stg_wr_data;
   logic [AW-1:0]    stg_rd_addr;
   logic [7:0]       stg_rd_data;
   back_status_type  back_status;

   assign recall_len_in = csr_wr_en ? csr_wr_data : recall_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         recall_len_ff <= RECALL_LEN_RESET;
      end else begin
         recall_len_ff <= recall_len_in;
      end
   end

   chr_front #(.RING_BYTES(RING_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .command     (req_command),
      .char_in     (req_char_in),
      .entry_id    (req_entry_id),
      .q_full      (q_full),
      .push        (push),
      .push_entry  (push_entry),
      .stg_wr_en   (stg_wr_en),
      .stg_wr_addr (stg_wr_addr),
      .stg_wr_data (stg_wr_data),
      .back_status (back_status)
   );

   chr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_staging (
      .clock   (clock),
      .wr_en   (stg_wr_en),
      .wr_addr (stg_wr_addr),
      .wr_data (stg_wr_data),
      .rd_addr (stg_rd_addr),
      .rd_data (stg_rd_data)
   );

   chr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   chr_back #(.RING_BYTES(RING_BYTES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .recall_len        (recall_len_ff),
      .stg_rd_addr       (stg_rd_addr),
      .stg_rd_data       (stg_rd_data),
      .back_status       (back_status),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_append_status (rsp_append_status),
      .rsp_out_char      (rsp_out_char),
      .rsp_length_code   (rsp_length_code),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_entry_count   (rsp_entry_count)
   );

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_result_kind == KIND_STATUS |-> rsp_last_of_run)
      else $error("append status not marked last");

   a_mid_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_run |-> rsp_out_char != 8'd0 && rsp_length_code == 7'sd0)
      else $error("inner recall byte malformed");

   a_no_pop_sweep: assert property (@(posedge clock) disable iff (reset)
      back_status.sweeping |-> !q_pop && !rsp_strobe)
      else $error("work during ring sweep");

endmodule

/* hw/rtl/chr_ram.sv */
module chr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/chr_queue.sv */
module chr_queue import chr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   entry_type  entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = entries_ff[rd_ptr_ff];

endmodule

/* hw/rtl/chr_front.sv */
module chr_front import chr_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   localparam int AW = $clog2(RING_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        command,
   input  logic [7:0]        char_in,
   input  logic signed [8:0] entry_id,
   input  logic              q_full,
   output logic              push,
   output entry_type         push_entry,
   output logic              stg_wr_en,
   output logic [AW-1:0]     stg_wr_addr,
   output logic [7:0]        stg_wr_data,
   input  back_status_type   back_status
);

   logic [AW:0] cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic        accept;

   assign busy   = q_full | pend_ff | back_status.sweeping;
   assign accept = start & ~busy;

   always_comb begin
      cnt_in           = cnt_ff;
      pend_in          = pend_ff & ~back_status.commit_done;
      push             = 1'b0;
      push_entry.op    = OP_CLEAR;
      push_entry.id    = entry_id;
      push_entry.count = CNT_W'(cnt_ff);
      stg_wr_en        = 1'b0;
      stg_wr_addr      = cnt_ff[AW-1:0];
      stg_wr_data      = char_in;
      if (accept) begin
         case (command)
            CMD_APPEND: begin
               if (char_in != 8'd0) begin
                  if (cnt_ff < (AW+1)'(RING_BYTES)) begin
                     stg_wr_en = 1'b1;
                     cnt_in    = cnt_ff + 1'b1;
                  end
               end else begin
                  push   = 1'b1;
                  cnt_in = '0;
                  if (cnt_ff == '0 || cnt_ff > (AW+1)'(RING_BYTES - 2)) begin
                     push_entry.op = OP_REJECT;
                  end else begin
                     push_entry.op = OP_COMMIT;
                     pend_in       = 1'b1;
                  end
               end
            end
            CMD_OLDER: begin
               push          = 1'b1;
               push_entry.op = OP_OLDER;
            end
            CMD_NEWER: begin
               push          = 1'b1;
               push_entry.op = OP_NEWER;
            end
            CMD_GET_ID: begin
               push          = 1'b1;
               push_entry.op = OP_GET_ID;
            end
            CMD_CLEAR: begin
               push          = 1'b1;
               push_entry.op = OP_CLEAR;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

endmodule

/* hw/rtl/chr_back.sv */
module chr_back import chr_pkg::*; #(
   parameter int RING_BYTES = RING_BYTES_DEF,
   localparam int AW = $clog2(RING_BYTES),
   localparam int CW = AW + 2,
   localparam int IW = (CW + 1 > 10) ? CW + 1 : 10,
   localparam int GW = AW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  entry_type         q_entry,
   output logic              q_pop,
   input  logic [CFG_W-1:0]  recall_len,
   output logic [AW-1:0]     stg_rd_addr,
   input  logic [7:0]        stg_rd_data,
   output back_status_type   back_status,
   output logic              rsp_strobe,
   output logic              rsp_result_kind,
   output logic [1:0]        rsp_append_status,
   output logic [7:0]        rsp_out_char,
   output logic signed [6:0] rsp_length_code,
   output logic              rsp_last_of_run,
   output logic [7:0]        rsp_entry_count
);

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      ptr_next = (p == AW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
      ptr_prev = (p == '0) ? AW'(RING_BYTES - 1) : p - 1'b1;
   endfunction

   back_state_type state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        tail_ff, tail_in;
   logic [AW:0]          lines_ff, lines_in;
   logic signed [CW-1:0] cursor_ff, cursor_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   op_type               mode_ff, mode_in;
   logic [AW-1:0]        p_ff, p_in;
   logic [IW-1:0]        walk_n_ff, walk_n_in;
   logic [IW-1:0]        walk_i_ff, walk_i_in;
   logic                 walk_back_ff, walk_back_in;
   logic [GW-1:0]        g_ff, g_in;
   logic [AW:0]          k_ff, k_in;
   logic [AW:0]          n_ff, n_in;
   logic                 term_ff, term_in;
   logic [CFG_W-1:0]     blen_ff, blen_in;
   logic [6:0]           ri_ff, ri_in;

   logic                 rsp_strobe_ff;
   logic                 rsp_kind_ff;
   logic [1:0]           rsp_status_ff;
   logic [7:0]           rsp_char_ff;
   logic [6:0]           rsp_len_ff;
   logic                 rsp_last_ff;
   logic [7:0]           rsp_count_ff;

   logic                 emit;
   logic                 e_kind;
   logic [1:0]           e_status;
   logic [7:0]           e_char;
   logic [6:0]           e_len;
   logic                 e_last;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [7:0]           ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [7:0]           ram_rd_data;

   logic signed [IW-1:0] loc_id;
   logic                 loc_neg;
   logic [IW-1:0]        loc_mag;
   logic                 loc_ok;
   logic [CFG_W-1:0]     blen_calc;
   logic [IW-1:0]        i_nx;
   logic [AW-1:0]        p_adj;
   logic [AW-1:0]        head_nx;
   logic [AW-1:0]        tail_nx;
   logic [AW:0]          lines_dec;
   logic [7:0]           stg_byte;
   logic                 rd_zero;

   chr_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (q_entry.op)
         OP_OLDER:  loc_id = IW'(cursor_ff) + '1;
         OP_NEWER:  loc_id = IW'(cursor_ff) + IW'(1);
         OP_GET_ID: loc_id = IW'(signed'(q_entry.id));
         default:   loc_id = '1;
      endcase
      loc_neg   = loc_id[IW-1];
      loc_mag   = loc_neg ? IW'(-loc_id) : IW'(loc_id);
      loc_ok    = (head_ff != tail_ff) &&
                  (loc_neg ? (loc_mag <= IW'(lines_ff)) : (loc_mag < IW'(lines_ff)));
      blen_calc = (recall_len > CFG_W'(RECALL_MAX)) ? CFG_W'(RECALL_MAX) : recall_len;
      rd_zero   = (ram_rd_data == 8'd0);
      stg_byte  = (k_ff < n_ff) ? stg_rd_data : 8'd0;
      head_nx   = ptr_next(head_ff);
      tail_nx   = ptr_next(tail_ff);
      lines_dec = (lines_ff != '0) ? lines_ff - 1'b1 : lines_ff;
      i_nx      = walk_i_ff + 1'b1;
      p_adj     = (rd_zero && !walk_back_ff) ? ptr_next(p_ff) : p_ff;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      lines_in     = lines_ff;
      cursor_in    = cursor_ff;
      sweep_in     = sweep_ff;
      mode_in      = mode_ff;
      p_in         = p_ff;
      walk_n_in    = walk_n_ff;
      walk_i_in    = walk_i_ff;
      walk_back_in = walk_back_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      term_in      = term_ff;
      blen_in      = blen_ff;
      ri_in        = ri_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      e_kind       = KIND_CHAR;
      e_status     = ST_STORED;
      e_char       = 8'd0;
      e_len        = 7'd0;
      e_last       = 1'b1;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = head_ff;
      ram_wr_data  = 8'd0;
      ram_rd_addr  = p_ff;
      stg_rd_addr  = k_ff[AW-1:0];
      back_status.sweeping    = (state_ff == BK_SWEEP);
      back_status.commit_done = 1'b0;

      case (state_ff)
         BK_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == AW'(RING_BYTES - 1)) begin
               sweep_in  = '0;
               head_in   = '0;
               tail_in   = '0;
               lines_in  = '0;
               cursor_in = '0;
               state_in  = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               mode_in   = q_entry.op;
               blen_in   = blen_calc;
               walk_n_in = loc_mag;
               walk_i_in = '0;
               g_in      = '0;
               k_in      = '0;
               ri_in     = '0;
               term_in   = 1'b0;
               case (q_entry.op)
                  OP_REJECT: begin
                     emit     = 1'b1;
                     e_kind   = KIND_STATUS;
                     e_status = ST_REJECT;
                  end
                  OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = BK_SWEEP;
                  end
                  OP_COMMIT: begin
                     cursor_in = '0;
                     n_in      = q_entry.count[AW:0];
                     if (loc_ok) begin
                        walk_back_in = 1'b1;
                        p_in         = ptr_prev(head_ff);
                        state_in     = BK_WALK_RD;
                     end else begin
                        state_in = BK_WR_RD;
                     end
                  end
                  OP_OLDER, OP_NEWER, OP_GET_ID: begin
                     if (q_entry.op == OP_NEWER && (cursor_ff == '0 || cursor_ff == '1)) begin
                        cursor_in = '0;
                        emit      = 1'b1;
                     end else if (blen_calc == '0 || !loc_ok) begin
                        emit = 1'b1;
                     end else if (loc_neg) begin
                        walk_back_in = 1'b1;
                        p_in         = ptr_prev(head_ff);
                        state_in     = BK_WALK_RD;
                     end else begin
                        walk_back_in = 1'b0;
                        p_in         = tail_ff;
                        state_in     = (loc_mag == '0) ? BK_RC_RD : BK_WALK_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_WALK_RD: begin
            p_in        = walk_back_ff ? ptr_prev(p_ff) : ptr_next(p_ff);
            ram_rd_addr = p_in;
            g_in        = g_ff + 1'b1;
            state_in    = BK_WALK_CHK;
         end
         BK_WALK_CHK: begin
            if (rd_zero || g_ff == GW'(RING_BYTES)) begin
               g_in      = '0;
               walk_i_in = i_nx;
               p_in      = p_adj;
               if (i_nx == walk_n_ff) begin
                  if (walk_back_ff) begin
                     p_in = ptr_next(p_ff);
                  end
                  state_in = (mode_ff == OP_COMMIT) ? BK_DUP_RD : BK_RC_RD;
               end else begin
                  state_in = BK_WALK_RD;
               end
            end else begin
               state_in = BK_WALK_RD;
            end
         end
         BK_DUP_RD: begin
            ram_rd_addr = p_ff;
            state_in    = BK_DUP_CHK;
         end
         BK_DUP_CHK: begin
            if (ram_rd_data != stg_byte) begin
               k_in     = '0;
               state_in = BK_WR_RD;
            end else if (rd_zero) begin
               emit                    = 1'b1;
               e_kind                  = KIND_STATUS;
               e_status                = ST_DUP;
               back_status.commit_done = 1'b1;
               state_in                = BK_IDLE;
            end else begin
               p_in     = ptr_next(p_ff);
               k_in     = k_ff + 1'b1;
               state_in = BK_DUP_RD;
            end
         end
         BK_WR_RD: begin
            state_in = BK_WR_DO;
         end
         BK_WR_DO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = head_ff;
            ram_wr_data = stg_byte;
            head_in     = head_nx;
            k_in        = k_ff + 1'b1;
            term_in     = (k_ff == n_ff);
            if (head_nx == tail_ff) begin
               g_in     = '0;
               state_in = BK_EV_ZERO;
            end else if (k_ff == n_ff) begin
               lines_in                = lines_ff + 1'b1;
               emit                    = 1'b1;
               e_kind                  = KIND_STATUS;
               e_status                = ST_STORED;
               back_status.commit_done = 1'b1;
               state_in                = BK_IDLE;
            end else begin
               state_in = BK_WR_RD;
            end
         end
         BK_EV_ZERO: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = tail_ff;
            tail_in     = tail_nx;
            ram_rd_addr = tail_nx;
            g_in        = g_ff + 1'b1;
            state_in    = BK_EV_CHK;
         end
         BK_EV_CHK: begin
            if (rd_zero || g_ff == GW'(RING_BYTES)) begin
               if (rd_zero) begin
                  tail_in = tail_nx;
               end
               lines_in = lines_dec;
               if (term_ff) begin
                  lines_in                = lines_dec + 1'b1;
                  emit                    = 1'b1;
                  e_kind                  = KIND_STATUS;
                  e_status                = ST_STORED;
                  back_status.commit_done = 1'b1;
                  state_in                = BK_IDLE;
               end else begin
                  state_in = BK_WR_RD;
               end
            end else begin
               state_in = BK_EV_ZERO;
            end
         end
         BK_RC_RD: begin
            ram_rd_addr = p_ff;
            state_in    = BK_RC_CHK;
         end
         BK_RC_CHK: begin
            emit = 1'b1;
            if (rd_zero) begin
               e_len    = ri_ff;
               state_in = BK_IDLE;
               if (ri_ff != 7'd0) begin
                  if (mode_ff == OP_OLDER) begin
                     cursor_in = cursor_ff - 1'b1;
                  end else if (mode_ff == OP_NEWER) begin
                     cursor_in = cursor_ff + 1'b1;
                  end
               end
            end else if (ri_ff == blen_ff - 1'b1) begin
               e_len    = 7'd1 - blen_ff;
               state_in = BK_IDLE;
            end else begin
               e_char   = ram_rd_data;
               e_last   = 1'b0;
               p_in     = ptr_next(p_ff);
               ri_in    = ri_ff + 1'b1;
               state_in = BK_RC_RD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_SWEEP;
         head_ff       <= '0;
         tail_ff       <= '0;
         lines_ff      <= '0;
         cursor_ff     <= '0;
         sweep_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         lines_ff      <= lines_in;
         cursor_ff     <= cursor_in;
         sweep_ff      <= sweep_in;
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      p_ff         <= p_in;
      walk_n_ff    <= walk_n_in;
      walk_i_ff    <= walk_i_in;
      walk_back_ff <= walk_back_in;
      g_ff         <= g_in;
      k_ff         <= k_in;
      n_ff         <= n_in;
      term_ff      <= term_in;
      blen_ff      <= blen_in;
      ri_ff        <= ri_in;
      rsp_kind_ff   <= e_kind;
      rsp_status_ff <= e_status;
      rsp_char_ff   <= e_char;
      rsp_len_ff    <= e_len;
      rsp_last_ff   <= e_last;
      rsp_count_ff  <= 8'(lines_in);
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_append_status = rsp_status_ff;
   assign rsp_out_char      = rsp_char_ff;
   assign rsp_length_code   = signed'(rsp_len_ff);
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

/* tb/command_history_ring_test.sv */
module command_history_ring_test;
   import chr_pkg::*;

   localparam int RING_N = RING_BYTES_DEF;
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 2500;

   typedef struct packed {
      logic              kind;
      logic [1:0]        status;
      logic [7:0]        ch;
      logic signed [6:0] len;
      logic              last;
      logic [7:0]        count;
   } rsp_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_command = CMD_APPEND;
   logic [7:0]        req_char_in = 8'd0;
   logic signed [8:0] req_entry_id = 9'sd0;
   logic              csr_wr_en = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = RECALL_LEN_RESET;
   logic              rsp_strobe;
   logic              rsp_result_kind;
   logic [1:0]        rsp_append_status;
   logic [7:0]        rsp_out_char;
   logic signed [6:0] rsp_length_code;
   logic              rsp_last_of_run;
   logic [7:0]        rsp_entry_count;

   command_history_ring dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_char_in(req_char_in),
      .req_entry_id(req_entry_id),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe), .rsp_result_kind(rsp_result_kind),
      .rsp_append_status(rsp_append_status), .rsp_out_char(rsp_out_char),
      .rsp_length_code(rsp_length_code), .rsp_last_of_run(rsp_last_of_run),
      .rsp_entry_count(rsp_entry_count)
   );

   // history model state
   logic [7:0] ring [RING_N];
   logic [7:0] head, tail;
   int         lines_stored, cursor;
   logic [7:0] staged [RING_N];
   int         staged_n;
   int         recall_len;

   rsp_word_type expected_words[$];
   int           mismatches, words_sent, words_checked, idle_pct;
   byte          last_line[$];

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic push_word(logic kind, logic [1:0] status, logic [7:0] ch, int len,
                            logic last);
      rsp_word_type w;
      w.kind = kind;
      w.status = status;
      w.ch = ch;
      w.len = len[6:0];
      w.last = last;
      w.count = lines_stored[7:0];
      expected_words.push_back(w);
   endtask

   function automatic bit find_entry(int id, output logic [7:0] pos);
      logic [7:0] p;
      if (head == tail) return 0;
      if (id < 0) begin
         if (-id > lines_stored) return 0;
         p = head - 8'd1;
         for (int i = 0; i < -id; i++)
            for (int g = 0; g < RING_N; g++) begin
               p = p - 8'd1;
               if (ring[p] == 8'd0) break;
            end
         pos = p + 8'd1;
      end else begin
         if (id >= lines_stored) return 0;
         p = tail;
         for (int i = 0; i < id; i++)
            for (int g = 0; g < RING_N; g++) begin
               p = p + 8'd1;
               if (ring[p] == 8'd0) begin
                  p = p + 8'd1;
                  break;
               end
            end
         pos = p;
      end
      return 1;
   endfunction

   task automatic recall_line(int id, output int len);
      int         blen;
      logic [7:0] p, c;
      blen = (recall_len > RECALL_MAX) ? RECALL_MAX : recall_len;
      if (blen == 0 || !find_entry(id, p)) begin
         push_word(KIND_CHAR, ST_STORED, 8'd0, 0, 1'b1);
         len = 0;
         return;
      end
      for (int i = 0; i < blen; i++) begin
         c = ring[p];
         p = p + 8'd1;
         if (c == 8'd0) begin
            push_word(KIND_CHAR, ST_STORED, 8'd0, i, 1'b1);
            len = i;
            return;
         end
         if (i == blen - 1) begin
            len = -(blen - 1);
            push_word(KIND_CHAR, ST_STORED, 8'd0, len, 1'b1);
            return;
         end
         push_word(KIND_CHAR, ST_STORED, c, 0, 1'b0);
      end
   endtask

   function automatic bit matches_newest();
      logic [7:0] p, c, s;
      if (!find_entry(-1, p)) return 0;
      for (int k = 0; k <= staged_n && k < RING_N; k++) begin
         c = ring[p];
         s = (k < staged_n) ? staged[k] : 8'd0;
         if (c != s) return 0;
         if (c == 8'd0) return 1;
         p = p + 8'd1;
      end
      return 0;
   endfunction

   function automatic void ring_write(logic [7:0] b);
      ring[head] = b;
      head = head + 8'd1;
      if (head != tail) return;
      for (int g = 0; g < RING_N; g++) begin
         ring[tail] = 8'd0;
         tail = tail + 8'd1;
         if (ring[tail] == 8'd0) begin
            tail = tail + 8'd1;
            break;
         end
      end
      if (lines_stored > 0) lines_stored--;
   endfunction

   function automatic logic [1:0] commit_line();
      int n;
      n = staged_n;
      staged_n = 0;
      if (n == 0 || n > RING_N - 2) return ST_REJECT;
      cursor = 0;
      staged_n = n;
      if (matches_newest()) begin
         staged_n = 0;
         return ST_DUP;
      end
      staged_n = 0;
      for (int k = 0; k < n; k++) ring_write(staged[k]);
      ring_write(8'd0);
      lines_stored++;
      return ST_STORED;
   endfunction

   function automatic void clear_history();
      foreach (ring[i]) ring[i] = 8'd0;
      head = 8'd0;
      tail = 8'd0;
      lines_stored = 0;
      cursor = 0;
   endfunction

   task automatic predict_word(logic [2:0] cmd, logic [7:0] ch, logic signed [8:0] id);
      int         len;
      logic [1:0] st;
      case (cmd)
         CMD_APPEND: begin
            if (ch != 8'd0) begin
               if (staged_n < RING_N) begin
                  staged[staged_n] = ch;
                  staged_n++;
               end
            end else begin
               st = commit_line();
               push_word(KIND_STATUS, st, 8'd0, 0, 1'b1);
            end
         end
         CMD_OLDER: begin
            recall_line(cursor - 1, len);
            if (len > 0) cursor--;
         end
         CMD_NEWER: begin
            if (cursor >= -1) begin
               cursor = 0;
               push_word(KIND_CHAR, ST_STORED, 8'd0, 0, 1'b1);
            end else begin
               recall_line(cursor + 1, len);
               if (len > 0) cursor++;
            end
         end
         CMD_GET_ID: recall_line(int'(id), len);
         CMD_CLEAR: clear_history();
         default: ;
      endcase
   endtask

   task automatic send_word(logic [2:0] cmd, logic [7:0] ch, logic signed [8:0] id);
      start <= 1'b1;
      req_command <= cmd;
      req_char_in <= ch;
      req_entry_id <= id;
      do @(posedge clock); while (busy);
      predict_word(cmd, ch, id);
      words_sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_line(int n, bit repeat_last);
      if (!repeat_last) begin
         last_line.delete();
         for (int i = 0; i < n; i++) last_line.push_back(byte'($urandom_range(1, 255)));
      end
      foreach (last_line[i]) send_word(CMD_APPEND, last_line[i], 9'($urandom));
      send_word(CMD_APPEND, 8'd0, 9'($urandom));
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_recall_len(logic [CFG_W-1:0] v);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      recall_len = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on word %0d: %s got %0d, expected %0d",
               words_checked, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, char", rsp_out_char, 0);
         end else begin
            w = expected_words.pop_front();
            if (rsp_result_kind !== w.kind) report_mismatch("kind", rsp_result_kind, w.kind);
            if (rsp_append_status !== w.status)
               report_mismatch("status", rsp_append_status, w.status);
            if (rsp_out_char !== w.ch) report_mismatch("char", rsp_out_char, w.ch);
            if (rsp_length_code !== w.len)
               report_mismatch("length", rsp_length_code, w.len);
            if (rsp_last_of_run !== w.last) report_mismatch("last", rsp_last_of_run, w.last);
            if (rsp_entry_count !== w.count)
               report_mismatch("count", rsp_entry_count, w.count);
         end
         words_checked++;
      end
   end

   task automatic test_directed();
      send_line(2, 0);
      send_line(2, 1);
      send_word(CMD_APPEND, 8'd0, 9'sd0);
      send_word(CMD_APPEND, 8'hff, 9'sd0);
      send_word(CMD_APPEND, 8'h01, -9'sd1);
      send_word(CMD_APPEND, 8'd0, 9'sd255);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      send_word(CMD_NEWER, 8'd0, 9'sd0);
      send_word(CMD_NEWER, 8'd0, 9'sd0);
      send_word(CMD_NEWER, 8'd0, 9'sd0);
      send_word(CMD_GET_ID, 8'd0, 9'sd0);
      send_word(CMD_GET_ID, 8'd0, -9'sd1);
      send_word(CMD_GET_ID, 8'd0, 9'sd255);
      send_word(CMD_GET_ID, 8'd0, -9'sd256);
      send_word(CMD_SPARE_LO, 8'h55, 9'sd3);
      send_word(CMD_SPARE_HI, 8'haa, -9'sd3);
      send_word(CMD_CLEAR, 8'd0, 9'sd0);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      send_word(CMD_GET_ID, 8'd0, 9'sd0);
   endtask

   task automatic test_overlong_line();
      send_line(RING_N - 2, 0);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      send_word(CMD_CLEAR, 8'd0, 9'sd0);
   endtask

   task automatic test_recall_sizes();
      send_line(10, 0);
      send_line(3, 0);
      write_recall_len(7'd1);
      send_word(CMD_GET_ID, 8'd0, -9'sd2);
      write_recall_len(7'd0);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      write_recall_len(7'd4);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      send_word(CMD_OLDER, 8'd0, 9'sd0);
      write_recall_len(7'd127);
      send_word(CMD_GET_ID, 8'd0, -9'sd1);
      write_recall_len(7'd11);
      send_word(CMD_GET_ID, 8'd0, 9'sd0);
      write_recall_len(7'd64);
   endtask

   task automatic test_random_traffic(int n_words, int pct);
      int goal, pick, len;
      idle_pct = pct;
      goal = words_sent + n_words;
      while (words_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 8);
            send_line(len, last_line.size() != 0 && $urandom_range(5) == 0);
         end else if (pick < 68) send_word(CMD_OLDER, 8'($urandom), 9'($urandom));
         else if (pick < 78) send_word(CMD_NEWER, 8'($urandom), 9'($urandom));
         else if (pick < 93)
            send_word(CMD_GET_ID, 8'($urandom),
                      ($urandom_range(1) != 0) ? 9'($urandom)
                                               : 9'($signed($urandom_range(0, 12)) - 6));
         else if (pick < 95) send_word(CMD_CLEAR, 8'($urandom), 9'($urandom));
         else if (pick < 97) send_word(CMD_APPEND, 8'd0, 9'($urandom));
         else send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 8'($urandom),
                        9'($urandom));
      end
   endtask

   initial begin
      mismatches = 0;
      words_sent = 0;
      words_checked = 0;
      idle_pct = 0;
      recall_len = RECALL_LEN_RESET;
      staged_n = 0;
      foreach (staged[i]) staged[i] = 8'd0;
      clear_history();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      idle_pct = 49;
      test_overlong_line();
      idle_pct = 0;
      test_recall_sizes();
      test_random_traffic(8, 0);
      write_recall_len(7'd7);
      test_random_traffic(8, 49);
      write_recall_len(7'd64);
      test_random_traffic(8, 0);
      test_random_traffic(8, 27);
      wait_quiet();
      $display("sent %0d words (appends, browsing, recall by id, clears, spare codes)",
               words_sent);
      $display("checked %0d result words across several recall buffer lengths",
               words_checked);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
